// ----- rtl/sparse_product_bank_conflict_counter_top_defines.svh -----
// ---------------------------------------------------------------------------
// assertion macros for the sparse product bank conflict counter
// ---------------------------------------------------------------------------
`ifndef SPARSE_PRODUCT_BANK_CONFLICT_COUNTER_TOP_DEFINES_SVH
`define SPARSE_PRODUCT_BANK_CONFLICT_COUNTER_TOP_DEFINES_SVH

// checked outside reset only
`define SPBC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked at every edge, reset included
`define SPBC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ----- rtl/spbc_pkg.sv -----
// ---------------------------------------------------------------------------
// spbc_pkg
// types, constants and helpers shared by the bank conflict counter
// ---------------------------------------------------------------------------
`default_nettype none

package spbc_pkg;

   localparam int NUM_BANKS_DEF = 32;
   localparam int ACT_LANES_DEF = 4;
   localparam int WGT_LANES_DEF = 4;

   localparam int COUNT_W     = 5;
   localparam int COORD_W     = 12;
   localparam int RECIP_W     = 16;
   localparam int RECIP_SHIFT = 15;
   localparam int PROD_W      = COORD_W + RECIP_W;
   localparam int CSR_ADDR_W  = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   typedef struct packed {
      logic [11:0] act_x;
      logic [11:0] act_y;
      logic [11:0] out_channel;
      logic [3:0]  kern_r;
      logic [3:0]  kern_s;
      logic        warp_last;
   } req_type;

   typedef struct packed {
      logic [4:0] warp_cycles;
      logic [4:0] valid_products;
      logic [7:0] idle_slots;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } bank_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_Y,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

   typedef enum logic [1:0] {
      CSR_STRIDE,
      CSR_WIDTH,
      CSR_HEIGHT
   } csr_idx_type;

   function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] cnt);
      logic [COUNT_W-1:0] res;
      res = (cnt < COUNT_MAX) ? cnt + 1'b1 : cnt;
      return res;
   endfunction

   // ceil(2^15 / stride), stride zero treated as one
   function automatic logic [RECIP_W-1:0] stride_recip(input logic [2:0] stride);
      logic [RECIP_W-1:0] res;
      case (stride)
         3'd2:    res = 16'd16384;
         3'd3:    res = 16'd10923;
         3'd4:    res = 16'd8192;
         3'd5:    res = 16'd6554;
         3'd6:    res = 16'd5462;
         3'd7:    res = 16'd4682;
         default: res = 16'd32768;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/sparse_product_bank_conflict_counter_top.sv -----
// ---------------------------------------------------------------------------
// sparse_product_bank_conflict_counter_top
// One activation-weight product pair is taken per pass of a three-step loop,
// only as the pair before is written back: the cycle of the transfer, which is
// also the write-back cycle of the pair before, a second pass through the shared
// reciprocal multiplier that divides the coordinate differences by the stride,
// and the bank memory read. The bank count read there is incremented and
// written back in the write-back cycle, where the next pair is taken, so the
// sustained pair rate is set by that loop around the one multiplier and the
// single-port bank memory. A pair with warp_last gives one result for the warp,
// valid after its write-back; the result register lets further pairs in while
// it waits, except that a second warp end waits in the write-back cycle until
// the first result is taken. Bank counts are cleared at once by valid bits, at
// reset and at each warp end, with no clearing pass.
// Registers: stride at 0x0, output width at 0x4, output height at 0x8.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sparse_product_bank_conflict_counter_top_defines.svh"

module sparse_product_bank_conflict_counter_top #(
   parameter int NUM_BANKS = spbc_pkg::NUM_BANKS_DEF,
   parameter int ACT_LANES = spbc_pkg::ACT_LANES_DEF,
   parameter int WGT_LANES = spbc_pkg::WGT_LANES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire spbc_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output spbc_pkg::rsp_type                      rsp_data,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [spbc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [31:0]                       pwdata,
   output logic      [31:0]                       prdata,
   output logic                                   pready
);

   localparam int IDX_W  = $clog2(NUM_BANKS);
   localparam int LANES  = ACT_LANES * WGT_LANES;
   localparam int LANE_W = $clog2(LANES + 1);
   localparam int IDLE_W = spbc_pkg::COUNT_W + LANE_W;
   localparam int CW     = spbc_pkg::COORD_W;
   localparam int SH     = spbc_pkg::RECIP_SHIFT;

   // configuration registers
   logic [2:0]    stride_ff;
   logic [CW-1:0] width_ff;
   logic [CW-1:0] height_ff;
   logic          csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= 3'd1;
         width_ff  <= 12'd1;
         height_ff <= 12'd1;
      end else if (csr_wr) begin
         case (spbc_pkg::csr_idx_type'(paddr[3:2]))
            spbc_pkg::CSR_STRIDE: stride_ff <= pwdata[2:0];
            spbc_pkg::CSR_WIDTH:  width_ff  <= pwdata[CW-1:0];
            spbc_pkg::CSR_HEIGHT: height_ff <= pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (spbc_pkg::csr_idx_type'(paddr[3:2]))
         spbc_pkg::CSR_STRIDE: prdata = {29'd0, stride_ff};
         spbc_pkg::CSR_WIDTH:  prdata = {20'd0, width_ff};
         spbc_pkg::CSR_HEIGHT: prdata = {20'd0, height_ff};
         default:              prdata = '0;
      endcase
   end

   // modulo table for the bank hash
   logic [IDX_W-1:0] mod_lut [32];
   for (genvar g = 0; g < 32; g++) begin : g_mod
      assign mod_lut[g] = IDX_W'(g % NUM_BANKS);
   end

   spbc_pkg::state_type    state_ff, state_in;
   spbc_pkg::bank_ctl_type bank_ctl;

   logic                         req_xfer;
   logic                         out_free;
   logic                         upd_done;

   // per-pair registers
   logic [CW-1:0]                diff_y_ff;
   logic                         neg_x_ff, neg_y_ff;
   logic [2:0]                   chan_ff;
   logic                         last_ff;
   logic [spbc_pkg::PROD_W-1:0]  prod_x_ff, prod_y_ff;
   logic                         pair_ok_ff;

   // warp accumulation
   logic [spbc_pkg::COUNT_W-1:0] product_ff, product_in;
   logic [spbc_pkg::COUNT_W-1:0] max_ff, max_in;

   logic                         rsp_valid_ff;
   spbc_pkg::rsp_type            rsp_data_ff;

   // shared reciprocal multiplier
   logic [CW-1:0]                diff_x;
   logic [CW-1:0]                mul_a;
   logic [spbc_pkg::PROD_W-1:0]  mul_p;

   assign diff_x = req_data.act_x - {8'd0, req_data.kern_r};
   assign mul_a  = (state_ff == spbc_pkg::ST_DIV_Y) ? diff_y_ff : diff_x;
   assign mul_p  = spbc_pkg::PROD_W'(mul_a) *
                   spbc_pkg::PROD_W'(spbc_pkg::stride_recip(stride_ff));

   // lookup
   logic [CW-1:0]                out_w, out_h;
   logic                         pair_ok;
   logic [4:0]                   hash;
   logic [IDX_W-1:0]             bank_idx;

   assign out_w    = prod_x_ff[SH+CW-1:SH];
   assign out_h    = prod_y_ff[SH+CW-1:SH];
   assign pair_ok  = !neg_x_ff && !neg_y_ff && (out_w < width_ff) && (out_h < height_ff);
   assign hash     = {chan_ff[2] ^ out_w[1] ^ out_h[1], out_w[0], out_h[0], chan_ff[1:0]};
   assign bank_idx = mod_lut[hash];

   logic [spbc_pkg::COUNT_W-1:0] new_count;

   spbc_bank #(
      .NUM_BANKS (NUM_BANKS)
   ) u_bank (
      .clock     (clock),
      .reset     (reset),
      .ctl       (bank_ctl),
      .rd_idx    (bank_idx),
      .new_count (new_count)
   );

   // result of the warp
   logic [spbc_pkg::COUNT_W-1:0] warp_max;
   logic [spbc_pkg::COUNT_W-1:0] warp_cycles;
   logic [IDLE_W-1:0]            idle_full;
   logic [7:0]                   idle_sat;

   always_comb begin
      warp_max = max_ff;
      if (pair_ok_ff && (new_count > max_ff)) begin
         warp_max = new_count;
      end
   end

   assign warp_cycles = (warp_max == '0) ? 5'd1 : warp_max;
   assign idle_full   = IDLE_W'(warp_cycles - 1'b1) * IDLE_W'(LANES);
   assign idle_sat    = (idle_full > IDLE_W'(255)) ? 8'd255 : idle_full[7:0];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      upd_done   = 1'b0;
      bank_ctl   = '0;
      product_in = product_ff;
      max_in     = max_ff;
      case (state_ff)
         spbc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = spbc_pkg::ST_DIV_Y;
            end
         end
         spbc_pkg::ST_DIV_Y: begin
            state_in = spbc_pkg::ST_LOOKUP;
         end
         spbc_pkg::ST_LOOKUP: begin
            bank_ctl.rd_en = 1'b1;
            state_in       = spbc_pkg::ST_UPDATE;
         end
         spbc_pkg::ST_UPDATE: begin
            upd_done = !last_ff || out_free;
            if (upd_done) begin
               req_ready      = 1'b1;
               bank_ctl.wr_en = pair_ok_ff;
               bank_ctl.clear = last_ff;
               max_in         = warp_max;
               if (pair_ok_ff) begin
                  product_in = spbc_pkg::count_inc(product_ff);
               end
               if (last_ff) begin
                  max_in     = '0;
                  product_in = '0;
               end
               state_in = req_valid ? spbc_pkg::ST_DIV_Y : spbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spbc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spbc_pkg::ST_IDLE;
         product_ff   <= '0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         product_ff <= product_in;
         max_ff     <= max_in;
         if (upd_done && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         diff_y_ff <= req_data.act_y - {8'd0, req_data.kern_s};
         neg_x_ff  <= req_data.act_x < {8'd0, req_data.kern_r};
         neg_y_ff  <= req_data.act_y < {8'd0, req_data.kern_s};
         chan_ff   <= req_data.out_channel[2:0];
         last_ff   <= req_data.warp_last;
         prod_x_ff <= mul_p;
      end
      if (state_ff == spbc_pkg::ST_DIV_Y) begin
         prod_y_ff <= mul_p;
      end
      if (state_ff == spbc_pkg::ST_LOOKUP) begin
         pair_ok_ff <= pair_ok;
      end
      if (upd_done && last_ff) begin
         rsp_data_ff.warp_cycles    <= warp_cycles;
         rsp_data_ff.valid_products <= pair_ok_ff ? spbc_pkg::count_inc(product_ff)
                                                  : product_ff;
         rsp_data_ff.idle_slots     <= idle_sat;
      end
   end

   `SPBC_ASSERT(a_accept_state,
      req_xfer |-> (state_ff == spbc_pkg::ST_IDLE || state_ff == spbc_pkg::ST_UPDATE),
      "transfer taken while a pair is in flight")
   `SPBC_ASSERT(a_rsp_origin,
      $rose(rsp_valid_ff) |-> $past(state_ff == spbc_pkg::ST_UPDATE && last_ff),
      "result raised without a warp end")
   `SPBC_ASSERT(a_max_bound, product_ff >= max_ff, "bank count above product count")
   `SPBC_ASSERT_ALWAYS(a_pready_high, pready, "configuration port not ready")

endmodule

`default_nettype wire

// ----- rtl/spbc_bank.sv -----
// ---------------------------------------------------------------------------
// spbc_bank
// bank count memory with per-entry valid bits and saturating update
// ---------------------------------------------------------------------------
`default_nettype none

module spbc_bank #(
   parameter int NUM_BANKS = spbc_pkg::NUM_BANKS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire spbc_pkg::bank_ctl_type             ctl,
   input  wire logic [$clog2(NUM_BANKS)-1:0]       rd_idx,
   output logic      [spbc_pkg::COUNT_W-1:0]       new_count
);

   localparam int IDX_W = $clog2(NUM_BANKS);

   logic [spbc_pkg::COUNT_W-1:0] mem [NUM_BANKS];
   logic [NUM_BANKS-1:0]         valid_ff;
   logic [NUM_BANKS-1:0]         valid_in;
   logic [IDX_W-1:0]             idx_ff;
   logic [spbc_pkg::COUNT_W-1:0] rd_data_ff;
   logic                         rd_valid_ff;

   assign new_count = spbc_pkg::count_inc(rd_valid_ff ? rd_data_ff : '0);

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff  <= mem[rd_idx];
         rd_valid_ff <= valid_ff[rd_idx];
         idx_ff      <= rd_idx;
      end
      if (ctl.wr_en) begin
         mem[idx_ff] <= new_count;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire
